>>> design/single_wire_sensor_frame_decoder_macros.svh
// Assertion macros for the single-wire sensor frame decoder checker.
// No dependencies; clock i_clk and reset i_rst_n are taken from the scope that uses them.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_MACROS_SVH

// Check a property outside reset.
`define SWSFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWSFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/swsfd_pkg.sv
// Shared types and constants for the single-wire sensor frame decoder.
// No dependencies.
package swsfd_pkg;

    localparam int FRAME_BITS = 40;
    localparam int LAST_IDX   = FRAME_BITS + 1;
    localparam int IDX_W      = $clog2(FRAME_BITS + 2);
    localparam int TIME_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int SHIFT_W    = 5 * BYTE_W;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [TIME_W-1:0] THRESH_RESET = 16'd362;

    // Register index, taken from paddr[2]
    localparam logic CFG_IDX_THRESH = 1'b0;

    localparam logic [IDX_W-1:0] IDX_RESPONSE  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_REFERENCE = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_FIRST_BIT = IDX_W'(2);

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] humidity_whole;
        logic [BYTE_W-1:0] humidity_frac;
        logic [BYTE_W-1:0] temp_whole;
        logic [BYTE_W-1:0] temp_frac;
        logic [BYTE_W-1:0] check_byte;
    } t_result;

endpackage

>>> design/single_wire_sensor_frame_decoder.sv
// Top level of the single-wire sensor frame decoder.
// Depends on swsfd_pkg, swsfd_cfg, swsfd_decode and swsfd_out_reg.
//
// The slave stream carries one falling-edge timestamp per transaction
// (s_axis_tdata = edge_time). The first edge of a frame is the response
// edge and is dropped, the second sets the reference time, and each later
// edge yields one bit of the 40-bit frame: 1 when the interval since the
// previous edge exceeds the threshold register. After the last bit one
// transaction leaves on the master stream with the five received bytes.
// Throughput: one edge per cycle unless the result side stalls, set by
// the single compare-and-shift stage. m_axis_tvalid rises once the input
// register has taken the last edge and the result register the frame.
// Reset clears the frame position, the previous time, the bit register and
// the result valid, and loads the threshold with 362 ticks.
// When the receiver stalls, the result is held; at most one more edge is
// taken into the input register, after which s_axis_tready drops until the
// result is taken. The APB port reads and writes the threshold where
// paddr[2] is 0; write it only while no frame is in progress.
module single_wire_sensor_frame_decoder
    import swsfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] edge_time
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] humidity_whole, [15:8] humidity_frac, [23:16] temp_whole,
    // [31:24] temp_frac, [39:32] check_byte
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    logic [TIME_W-1:0] w_thresh;
    logic              w_res_rdy;
    t_result           w_res;

    swsfd_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_thresh (w_thresh)
    );

    swsfd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .i_in_time (s_axis_tdata),
        .o_in_rdy  (s_axis_tready),
        .i_thresh  (w_thresh),
        .i_res_rdy (w_res_rdy),
        .o_res     (w_res)
    );

    swsfd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (w_res),
        .o_res_rdy (w_res_rdy),
        .o_vld     (m_axis_tvalid),
        .i_rdy     (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

>>> design/swsfd_cfg.sv
// APB register block holding the one-bit interval threshold.
// Depends on swsfd_pkg.
module swsfd_cfg
    import swsfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [TIME_W-1:0] o_thresh
);

    logic [TIME_W-1:0] r_thresh;
    logic              w_hit;

    assign w_hit  = (paddr[2] == CFG_IDX_THRESH);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_thresh <= pwdata[TIME_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = APB_DW'(r_thresh);
        end
    end

    assign o_thresh = r_thresh;

endmodule

>>> design/swsfd_decode.sv
// Edge input register and frame decode: interval compare, bit shift, frame position.
// Depends on swsfd_pkg.
module swsfd_decode
    import swsfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_vld,
    input  logic [TIME_W-1:0] i_in_time,
    output logic              o_in_rdy,
    input  logic [TIME_W-1:0] i_thresh,
    input  logic              i_res_rdy,
    output t_result           o_res
);

    logic               r_s1_vld;
    logic [TIME_W-1:0]  r_s1_time;
    logic [IDX_W-1:0]   r_idx;
    logic [TIME_W-1:0]  r_prev;
    logic [SHIFT_W-1:0] r_shift;

    logic [IDX_W-1:0]   n_idx;
    logic [TIME_W-1:0]  n_prev;
    logic [SHIFT_W-1:0] n_shift;

    logic               w_adv;
    logic               w_done;
    logic [TIME_W-1:0]  w_interval;
    logic               w_bit;

    assign w_adv      = r_s1_vld && i_res_rdy;
    assign o_in_rdy   = !r_s1_vld || i_res_rdy;
    assign w_interval = r_s1_time - r_prev;
    assign w_bit      = (w_interval > i_thresh);

    always_comb begin
        n_idx  = r_idx;
        n_prev = r_prev;
        n_shift = r_shift;
        w_done = 1'b0;
        if (w_adv) begin
            if (r_idx == IDX_RESPONSE) begin
                n_idx = IDX_REFERENCE;
            end else if (r_idx == IDX_REFERENCE) begin
                n_prev  = r_s1_time;
                n_shift = '0;
                n_idx   = IDX_FIRST_BIT;
            end else begin
                n_prev  = r_s1_time;
                n_shift = {r_shift[SHIFT_W-2:0], w_bit};
                if (r_idx >= IDX_W'(LAST_IDX)) begin
                    w_done = 1'b1;
                    n_idx  = IDX_RESPONSE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_idx    <= IDX_RESPONSE;
            r_prev   <= '0;
            r_shift  <= '0;
        end else begin
            if (o_in_rdy) begin
                r_s1_vld <= i_in_vld;
            end
            r_idx   <= n_idx;
            r_prev  <= n_prev;
            r_shift <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_rdy && i_in_vld) begin
            r_s1_time <= i_in_time;
        end
    end

    always_comb begin
        o_res.vld            = w_done;
        o_res.humidity_whole = n_shift[39:32];
        o_res.humidity_frac  = n_shift[31:24];
        o_res.temp_whole     = n_shift[23:16];
        o_res.temp_frac      = n_shift[15:8];
        o_res.check_byte     = n_shift[7:0];
    end

endmodule

>>> design/swsfd_out_reg.sv
// Result register for the master-side stream; holds a frame until it is taken.
// Depends on swsfd_pkg.
module swsfd_out_reg
    import swsfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_result               i_res,
    output logic                  o_res_rdy,
    output logic                  o_vld,
    input  logic                  i_rdy,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic                  r_vld;
    logic [OUT_DATA_W-1:0] r_data;

    assign o_res_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_res_rdy) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_rdy && i_res.vld) begin
            r_data <= {i_res.check_byte, i_res.temp_frac, i_res.temp_whole,
                       i_res.humidity_frac, i_res.humidity_whole};
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

>>> design/swsfd_checker.sv
// Port-level checker for the single-wire sensor frame decoder, bound to the top level.
// Depends on swsfd_pkg and single_wire_sensor_frame_decoder_macros.svh.
`include "single_wire_sensor_frame_decoder_macros.svh"

module swsfd_checker
    import swsfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] edge_time
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] humidity_whole, [15:8] humidity_frac, [23:16] temp_whole,
    // [31:24] temp_frac, [39:32] check_byte
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    input  logic [APB_DW-1:0]     prdata,
    input  logic                  pready
);

    `SWSFD_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    `SWSFD_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
    `SWSFD_ASSERT(a_pready_high, psel |-> pready, "APB wait state")
    `SWSFD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
    `SWSFD_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed")

endmodule

bind single_wire_sensor_frame_decoder swsfd_checker u_swsfd_checker (.*);

>>> tb/tb_single_wire_sensor_frame_decoder.sv
// Self-checking testbench for single_wire_sensor_frame_decoder: streams edge timestamps
// as whole frames, predicts each decoded frame's five bytes and checks every transaction.
// Depends on swsfd_pkg and the design; no other files.
module tb_single_wire_sensor_frame_decoder;
    import swsfd_pkg::*;

    localparam logic [APB_AW-1:0] THRESH_ADDR = APB_AW'({CFG_IDX_THRESH, 2'b00});
    localparam logic [TIME_W-1:0] THRESH_MAX  = {TIME_W{1'b1}};

    typedef enum int {FRAME_SHAPED, FRAME_NOISE} t_frame_style;

    typedef struct packed {
        logic [BYTE_W-1:0] humidity_whole;
        logic [BYTE_W-1:0] humidity_frac;
        logic [BYTE_W-1:0] temp_whole;
        logic [BYTE_W-1:0] temp_frac;
        logic [BYTE_W-1:0] check_byte;
    } t_reading;

    class t_sensor_frame_board;
        logic [TIME_W-1:0] thresh;
        int unsigned       edge_pos;
        logic [TIME_W-1:0] last_stamp;
        logic [63:0]       bits_in;
        t_reading          pending[$];
        int unsigned       errors;

        function new();
            thresh     = THRESH_RESET;
            edge_pos   = 0;
            last_stamp = '0;
            bits_in    = '0;
            errors     = 0;
        endfunction

        function void set_threshold(input logic [TIME_W-1:0] value);
            thresh = value;
        endfunction

        function void note_edge(input logic [TIME_W-1:0] stamp);
            logic [TIME_W-1:0] gap;
            t_reading          r;
            if (edge_pos == 0) begin
                edge_pos = 1;
            end else if (edge_pos == 1) begin
                last_stamp = stamp;
                bits_in    = '0;
                edge_pos   = 2;
            end else begin
                gap        = stamp - last_stamp;
                bits_in    = {bits_in[62:0], gap > thresh};
                last_stamp = stamp;
                if (edge_pos >= FRAME_BITS + 1) begin
                    r.humidity_whole = bits_in[39:32];
                    r.humidity_frac  = bits_in[31:24];
                    r.temp_whole     = bits_in[23:16];
                    r.temp_frac      = bits_in[15:8];
                    r.check_byte     = bits_in[7:0];
                    pending.push_back(r);
                    edge_pos = 0;
                end else begin
                    edge_pos++;
                end
            end
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] d);
            t_reading exp_r;
            t_reading got;
            got.humidity_whole = d[7:0];
            got.humidity_frac  = d[15:8];
            got.temp_whole     = d[23:16];
            got.temp_frac      = d[31:24];
            got.check_byte     = d[39:32];
            if (pending.size() == 0) begin
                $display("%0t: unexpected frame, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.humidity_whole !== exp_r.humidity_whole) begin
                $display("%0t: humidity_whole expected %h actual %h",
                         $time, exp_r.humidity_whole, got.humidity_whole);
                errors++;
            end
            if (got.humidity_frac !== exp_r.humidity_frac) begin
                $display("%0t: humidity_frac expected %h actual %h",
                         $time, exp_r.humidity_frac, got.humidity_frac);
                errors++;
            end
            if (got.temp_whole !== exp_r.temp_whole) begin
                $display("%0t: temp_whole expected %h actual %h",
                         $time, exp_r.temp_whole, got.temp_whole);
                errors++;
            end
            if (got.temp_frac !== exp_r.temp_frac) begin
                $display("%0t: temp_frac expected %h actual %h",
                         $time, exp_r.temp_frac, got.temp_frac);
                errors++;
            end
            if (got.check_byte !== exp_r.check_byte) begin
                $display("%0t: check_byte expected %h actual %h",
                         $time, exp_r.check_byte, got.check_byte);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] edge_time
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] humidity_whole, [15:8] humidity_frac, [23:16] temp_whole,
    // [31:24] temp_frac, [39:32] check_byte
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    t_sensor_frame_board sb = new();
    logic [TIME_W-1:0] cur_thresh = THRESH_RESET;
    bit                calm = 1'b0;

    single_wire_sensor_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end

    task automatic send_edge(input logic [TIME_W-1:0] stamp);
        if (!calm && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_edge(stamp);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [TIME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESH_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_threshold(value);
        cur_thresh = value;
    endtask

    function automatic logic [TIME_W-1:0] gap_for(input logic one);
        int unsigned lo;
        int unsigned hi;
        if (one && cur_thresh != THRESH_MAX) begin
            lo = cur_thresh + 1;
            hi = THRESH_MAX;
        end else begin
            lo = 0;
            hi = cur_thresh;
        end
        case ($urandom_range(3))
            0: return TIME_W'(lo);
            1: return TIME_W'(hi);
            default: return TIME_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic send_frame(input t_frame_style style);
        logic [SHIFT_W-1:0] payload;
        logic [TIME_W-1:0]  stamp;
        int                 i;
        payload = SHIFT_W'({$urandom, $urandom});
        send_edge(TIME_W'($urandom));
        stamp = TIME_W'($urandom);
        send_edge(stamp);
        for (i = FRAME_BITS - 1; i >= 0; i--) begin
            if (style == FRAME_NOISE) begin
                stamp = TIME_W'($urandom);
            end else begin
                stamp = stamp + gap_for(payload[i % SHIFT_W]);
            end
            send_edge(stamp);
        end
    endtask

    initial begin
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] gaps[5];
        int                i;
        int                phase;
        int                f;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold, wrap on the first interval, gap extremes
        gaps = '{16'd362, 16'd363, 16'd0, 16'hFFFF, 16'd1};
        send_edge(16'h0000);
        stamp = 16'hFFFF;
        send_edge(stamp);
        for (i = 0; i < FRAME_BITS; i++) begin
            stamp = stamp + ((i < 5) ? gaps[i] : gap_for($urandom_range(1)));
            send_edge(stamp);
        end
        wait_drained();

        // threshold at maximum: every bit decodes as zero
        write_threshold(THRESH_MAX);
        send_frame(FRAME_SHAPED);
        wait_drained();

        // threshold zero: any nonzero gap is a one
        write_threshold('0);
        send_edge(16'hFFFF);
        stamp = 16'hFFF0;
        send_edge(stamp);
        for (i = 0; i < FRAME_BITS; i++) begin
            stamp = stamp + TIME_W'(i % 2);
            send_edge(stamp);
        end
        wait_drained();

        for (phase = 0; phase < 10; phase++) begin
            case ($urandom_range(4))
                0: write_threshold('0);
                1: write_threshold(THRESH_MAX);
                2: write_threshold(THRESH_RESET);
                3: write_threshold(TIME_W'($urandom));
                default: write_threshold(TIME_W'($urandom_range(1000, 50)));
            endcase
            calm = (phase == 4);
            for (f = 0; f < 4; f++) begin
                send_frame(($urandom_range(4) == 0) ? FRAME_NOISE : FRAME_SHAPED);
            end
            wait_drained();
        end
        calm = 1'b0;

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
